// ===== sv/adcsm_pkg.sv =====
// Shared constants for the ADC smoothing and moving-average block.
package adcsm_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int ALPHA_W  = 9;

  // Q8 unity for the smoothing coefficient
  localparam logic [ALPHA_W-1:0] Q8_ONE      = 9'd256;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd26;

  // Boxcar depth is a power of two, set by its log2 (1..6 gives 2..64 entries)
  localparam int AVG_LOG2  = 3;
  localparam int AVG_DEPTH = 1 << AVG_LOG2;
  localparam int PTR_W     = AVG_LOG2;
  localparam int SUM_W     = SAMPLE_W + AVG_LOG2;

  // Stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

endpackage

// ===== sv/adc_smoothing_and_moving_average.sv =====
// Top level: first-order smoothing filter feeding a boxcar moving average.
// An accepted input item passes the stage 1 register and the output register to out_tvalid.
// One item per cycle unless out_tready stalls the output; the filter feedback closes in the accept cycle
// and the ring read-modify-write uses one RAM read and one RAM write per item.
// Reset (rst_n low, synchronous): alpha returns to 26, filter state, pointer and
// sum clear, and per-entry valid bits make every ring entry read as zero.
module adc_smoothing_and_moving_average
  import adcsm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [11:0] sample, [15:12] zero
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [11:0] smoothed, [23:12] average
  // Configuration
  input  logic                   cfg_wr_en,
  input  logic [ALPHA_W-1:0]     cfg_wr_data // smoothing_alpha
);

  logic [ALPHA_W-1:0]   alpha_r;
  logic [SAMPLE_W-1:0]  prev_r, prev_nxt;
  logic [PTR_W-1:0]     wp_r;
  logic [AVG_DEPTH-1:0] vld_r;
  logic [SUM_W-1:0]     sum_r, sum_nxt;

  logic                 s1_valid_r;
  logic [SAMPLE_W-1:0]  s1_smooth_r;
  logic [PTR_W-1:0]     s1_slot_r;
  logic                 s1_vld_r;

  logic                 out_valid_r;
  logic [SAMPLE_W-1:0]  out_smooth_r;
  logic [SAMPLE_W-1:0]  out_avg_r;

  logic                 in_accept;
  logic                 s1_adv;
  logic [SAMPLE_W-1:0]  sample;
  logic [ALPHA_W-1:0]   alpha_sat;
  logic signed [SAMPLE_W:0]     diff;
  logic signed [SAMPLE_W+ALPHA_W+1:0] prod;
  logic signed [SAMPLE_W+2:0]   corr;
  logic signed [SAMPLE_W+2:0]   mix;
  logic [SAMPLE_W-1:0]  ram_rdata;
  logic [SAMPLE_W-1:0]  old_val;

  // Handshake: stage 1 moves when the output register is free or being taken
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_accept = in_tvalid && in_tready;

  // Smoothing: s + floor((p - s) * a / 256), same as the Q8 weighted mix
  assign sample    = in_tdata[SAMPLE_W-1:0];
  assign alpha_sat = (alpha_r > Q8_ONE) ? Q8_ONE : alpha_r;
  assign diff      = $signed({1'b0, prev_r}) - $signed({1'b0, sample});
  assign prod      = diff * $signed({1'b0, alpha_sat});
  assign corr      = (SAMPLE_W+3)'(prod >>> 8);
  assign mix       = $signed({3'b000, sample}) + corr;
  assign prev_nxt  = mix[SAMPLE_W-1:0];

  // Ring storage; consecutive items hit distinct slots, so no forwarding is needed
  adcsm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (AVG_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (s1_valid_r && s1_adv),
    .waddr (s1_slot_r),
    .wdata (s1_smooth_r),
    .re    (in_accept),
    .raddr (wp_r),
    .rdata (ram_rdata)
  );

  // Unwritten entries count as zero
  assign old_val = s1_vld_r ? ram_rdata : '0;
  assign sum_nxt = sum_r - {{AVG_LOG2{1'b0}}, old_val} + {{AVG_LOG2{1'b0}}, s1_smooth_r};

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
    end else if (cfg_wr_en) begin
      alpha_r <= cfg_wr_data;
    end
  end

  // Stage 0: filter feedback, pointer and read issue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      wp_r       <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        prev_r <= prev_nxt;
        wp_r   <= wp_r + 1'b1;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_smooth_r <= prev_nxt;
      s1_slot_r   <= wp_r;
      s1_vld_r    <= vld_r[wp_r];
    end
  end

  // Stage 1: sum update, valid bits, output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_valid_r && s1_adv) begin
        sum_r            <= sum_nxt;
        vld_r[s1_slot_r] <= 1'b1;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_smooth_r <= s1_smooth_r;
      out_avg_r    <= sum_nxt[SUM_W-1:AVG_LOG2];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_avg_r, out_smooth_r};

`ifndef SYNTH
  // The slot being read never collides with the slot still waiting to be written
  a_no_slot_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && s1_valid_r) |-> (wp_r != s1_slot_r))
    else $error("ring read and pending write target the same slot");

  // Pointer advances by one per accepted item
  a_ptr_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (wp_r == $past(wp_r) + 1'b1))
    else $error("write pointer did not advance");

  // With zero alpha the filter passes the sample straight through
  a_alpha_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && alpha_r == '0) |=> (prev_r == $past(in_tdata[SAMPLE_W-1:0])))
    else $error("zero alpha did not pass the sample");

  // A stalled stage 1 keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_smooth_r)))
    else $error("stage 1 item lost under stall");
`endif

endmodule

// ===== sv/adcsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module adcsm_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port: hold the last read when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
